@@ rtl/fpt_pkg.sv @@
// ----------------------------------------------------------------------------
// fpt_pkg
// Types, constants and state codes shared by the flow pulse totalizer.
// ----------------------------------------------------------------------------
package fpt_pkg;

   // defaults for the top level parameters
   localparam int TABLE_DEPTH_DEF = 10;
   localparam int PULSE_BITS_DEF  = 24;

   // configuration register reset values, unsigned Q8.8
   localparam logic [15:0] K_FACTOR_RESET = 16'd1920;
   localparam logic [15:0] CAPACITY_RESET = 16'd7680;

   // configuration register indexes
   localparam int          CSR_INDEX_BITS    = 2;
   localparam logic [1:0]  CSR_K_FACTOR      = 2'd0;
   localparam logic [1:0]  CSR_CAPACITY_FLOW = 2'd1;

   // fixed scale factors: 1000 ms * 256 (Q.8) and 1e6 ul / 60 s / 64 / 12 * ...
   localparam logic [31:0] FREQ_SCALE = 32'd256000;
   localparam logic [31:0] VOL_SCALE  = 32'd3125;

   // serial divider geometry
   localparam int DIV_HI_BITS  = 48;
   localparam int DIV_BITS     = 32;
   localparam int DIV_CNT_BITS = 6;

   // quotient bit counts for the four divisions
   localparam logic [DIV_CNT_BITS-1:0] QW_FREQ = 6'd32;
   localparam logic [DIV_CNT_BITS-1:0] QW_DEC  = 6'd4;
   localparam logic [DIV_CNT_BITS-1:0] QW_RATE = 6'd24;
   localparam logic [DIV_CNT_BITS-1:0] QW_VOL  = 6'd32;

   typedef enum logic [1:0] {
      CMD_PULSE   = 2'd0,
      CMD_UPDATE  = 2'd1,
      CMD_LOAD    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_F,
      ST_DIVS_F,
      ST_DIVW_F,
      ST_MUL_CK,
      ST_MUL_DN,
      ST_DIVS_D,
      ST_DIVW_D,
      ST_RD_M,
      ST_MUL_R,
      ST_DIVS_R,
      ST_DIVW_R,
      ST_MUL_V1,
      ST_MUL_V2,
      ST_DIVS_V,
      ST_DIVW_V,
      ST_ACC
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] duration_ms;
      logic [3:0]  table_index;
      logic [15:0] table_value;
   } req_type;

   typedef struct packed {
      logic [31:0] frequency;
      logic [3:0]  decile;
      logic [23:0] flow_rate;
      logic [31:0] interval_volume;
      logic [47:0] total_volume;
      logic [39:0] total_time;
   } rsp_type;

   // numerator is split: num_hi = N >> qbits, num_lo = low qbits of N, left aligned
   typedef struct packed {
      logic                    start;
      logic [DIV_HI_BITS-1:0]  num_hi;
      logic [DIV_BITS-1:0]     num_lo;
      logic [DIV_BITS-1:0]     den;
      logic [DIV_CNT_BITS-1:0] qbits;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quot;
   } div_rsp_type;

endpackage

@@ rtl/fpt_div.sv @@
// ----------------------------------------------------------------------------
// fpt_div
// Bit-serial restoring divider with saturation. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpt_div (
   input  logic                clock,
   input  logic                reset,
   input  fpt_pkg::div_cmd_type cmd,
   output fpt_pkg::div_rsp_type rsp
);
   import fpt_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     lo_ff, lo_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_BITS-1:0]     den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS:0]       trial;
   logic                    fits;
   logic                    overflow;

   // quotient needs more than qbits bits when the high part already reaches den
   assign overflow = cmd.num_hi >= DIV_HI_BITS'(cmd.den);
   assign trial    = {rem_ff, lo_ff[DIV_BITS-1]};
   assign fits     = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         den_in = cmd.den;
         lo_in  = cmd.num_lo;
         cnt_in = cmd.qbits;
         if (overflow) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            quo_in  = '0;
            rem_in  = cmd.num_hi[DIV_BITS-1:0];
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? DIV_BITS'(trial - {1'b0, den_ff}) : trial[DIV_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         lo_in  = {lo_ff[DIV_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff && !done_ff)
      else $error("divider started while a division is in flight");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

endmodule

@@ rtl/fpt_mtab.sv @@
// ----------------------------------------------------------------------------
// fpt_mtab
// m-factor table, one entry per decile, registered read.
// ----------------------------------------------------------------------------
module fpt_mtab #(
   parameter int TABLE_DEPTH = fpt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [15:0]                    wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [15:0]                    rd_data
);
   logic [15:0] mfac_mem_ff [TABLE_DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mfac_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mfac_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/flow_pulse_totalizer.sv @@
// ----------------------------------------------------------------------------
// flow_pulse_totalizer
// Flow sensor pulse counter with k-factor/m-factor correction and totals.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall    fpt_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall    fpt_pkg::rsp_type
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// pulse, load and restart transfers are taken back to back while no update runs.
// an update runs four serial divisions at one quotient bit per cycle
// (32 + 4 + 24 + 32 bits) plus multiply and table steps.
// reset is synchronous; it clears count and totals and presets k and capacity.
// a finished result sits in the output register; a stalled rsp only holds
// the next update at its final step, and req stays stalled while it waits.
// ----------------------------------------------------------------------------
module flow_pulse_totalizer #(
   parameter int TABLE_DEPTH = fpt_pkg::TABLE_DEPTH_DEF,
   parameter int PULSE_BITS  = fpt_pkg::PULSE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fpt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fpt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                        csr_data
);
   import fpt_pkg::*;

   localparam int          AW       = $clog2(TABLE_DEPTH);
   localparam logic [3:0]  DEC_MAX  = 4'(TABLE_DEPTH - 1);
   localparam logic [31:0] DEC_SCALE = 32'(TABLE_DEPTH * 256);

   fsm_state_type state_ff, state_in;

   logic [PULSE_BITS-1:0] pulse_count_ff;
   logic [15:0]           k_ff;
   logic [15:0]           cap_ff;
   logic [15:0]           dur_ff;
   logic [63:0]           prod_ff;
   logic [63:0]           prod_in;
   logic [31:0]           ck_ff;
   logic [31:0]           freq_ff;
   logic [3:0]            dec_ff;
   logic [23:0]           rate_ff;
   logic [31:0]           vol_ff;
   logic [47:0]           vol_sum_ff, vol_sum_in;
   logic [39:0]           dur_sum_ff, dur_sum_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [48:0]           vol_add;
   logic [40:0]           dur_add;
   logic [31:0]           p32;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic                  mul_en;
   logic                  req_acc;
   logic                  acc_go;
   logic                  tab_wr_en;
   logic                  tab_rd_en;
   logic [15:0]           mfac;
   logic [31:0]           k_x12;
   logic [3:0]            dec_q;
   div_cmd_type           div_cmd;
   div_rsp_type           div_rsp;

   assign req_acc   = req_valid && !req_stall;
   assign acc_go    = (state_ff == ST_ACC) && (!rsp_valid_ff || !rsp_stall);
   assign p32       = 32'(pulse_count_ff);
   assign prod_in   = mul_a * mul_b;
   assign k_x12     = {13'b0, k_ff, 3'b0} + {14'b0, k_ff, 2'b0};
   assign tab_wr_en = req_acc && (req_data.command == CMD_LOAD)
                      && ({1'b0, req_data.table_index} < 5'(TABLE_DEPTH));
   assign dec_q     = (div_rsp.quot[3:0] > DEC_MAX) ? DEC_MAX : div_rsp.quot[3:0];
   assign csr_ready = 1'b1;

   // saturating totals
   assign vol_add    = {1'b0, vol_sum_ff} + 49'(vol_ff);
   assign dur_add    = {1'b0, dur_sum_ff} + 41'(dur_ff);
   assign vol_sum_in = vol_add[48] ? '1 : vol_add[47:0];
   assign dur_sum_in = dur_add[40] ? '1 : dur_add[39:0];

   fpt_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   fpt_mtab #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mtab (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (req_data.table_index[AW-1:0]),
      .wr_data (req_data.table_value),
      .rd_en   (tab_rd_en),
      .rd_addr (dec_ff[AW-1:0]),
      .rd_data (mfac)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.command == CMD_UPDATE) state_in = ST_MUL_F;
         end
         ST_MUL_F:  state_in = ST_DIVS_F;
         ST_DIVS_F: state_in = ST_DIVW_F;
         ST_DIVW_F: begin
            if (div_rsp.done) state_in = ST_MUL_CK;
         end
         ST_MUL_CK: state_in = ST_MUL_DN;
         ST_MUL_DN: state_in = ST_DIVS_D;
         ST_DIVS_D: state_in = ST_DIVW_D;
         ST_DIVW_D: begin
            if (div_rsp.done) state_in = ST_RD_M;
         end
         ST_RD_M:   state_in = ST_MUL_R;
         ST_MUL_R:  state_in = ST_DIVS_R;
         ST_DIVS_R: state_in = ST_DIVW_R;
         ST_DIVW_R: begin
            if (div_rsp.done) state_in = ST_MUL_V1;
         end
         ST_MUL_V1: state_in = ST_MUL_V2;
         ST_MUL_V2: state_in = ST_DIVS_V;
         ST_DIVS_V: state_in = ST_DIVW_V;
         ST_DIVW_V: begin
            if (div_rsp.done) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (acc_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: multiplier operands, divider launch, table read, req stall
   always_comb begin
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_cmd   = '0;
      tab_rd_en = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_MUL_F: begin
            mul_en = 1'b1;
            mul_a  = p32;
            mul_b  = FREQ_SCALE;
         end
         ST_DIVS_F: begin
            div_cmd.start  = 1'b1;
            div_cmd.num_hi = {16'b0, prod_ff[63:32]};
            div_cmd.num_lo = prod_ff[31:0];
            div_cmd.den    = {16'b0, dur_ff};
            div_cmd.qbits  = QW_FREQ;
         end
         ST_MUL_CK: begin
            mul_en = 1'b1;
            mul_a  = {16'b0, cap_ff};
            mul_b  = {16'b0, k_ff};
         end
         ST_MUL_DN: begin
            mul_en = 1'b1;
            mul_a  = freq_ff;
            mul_b  = DEC_SCALE;
         end
         ST_DIVS_D: begin
            div_cmd.start  = 1'b1;
            div_cmd.num_hi = prod_ff[51:4];
            div_cmd.num_lo = {prod_ff[3:0], 28'b0};
            div_cmd.den    = ck_ff;
            div_cmd.qbits  = QW_DEC;
         end
         ST_RD_M: begin
            tab_rd_en = 1'b1;
         end
         ST_MUL_R: begin
            mul_en = 1'b1;
            mul_a  = freq_ff;
            mul_b  = {16'b0, mfac};
         end
         ST_DIVS_R: begin
            // divisor 64 * k
            div_cmd.start  = 1'b1;
            div_cmd.num_hi = {8'b0, prod_ff[63:24]};
            div_cmd.num_lo = {prod_ff[23:0], 8'b0};
            div_cmd.den    = {10'b0, k_ff, 6'b0};
            div_cmd.qbits  = QW_RATE;
         end
         ST_MUL_V1: begin
            mul_en = 1'b1;
            mul_a  = {16'b0, mfac};
            mul_b  = VOL_SCALE;
         end
         ST_MUL_V2: begin
            mul_en = 1'b1;
            mul_a  = p32;
            mul_b  = prod_ff[31:0];
         end
         ST_DIVS_V: begin
            div_cmd.start  = 1'b1;
            div_cmd.num_hi = {16'b0, prod_ff[63:32]};
            div_cmd.num_lo = prod_ff[31:0];
            div_cmd.den    = k_x12;
            div_cmd.qbits  = QW_VOL;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pulse_count_ff <= '0;
         k_ff           <= K_FACTOR_RESET;
         cap_ff         <= CAPACITY_RESET;
         vol_sum_ff     <= '0;
         dur_sum_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_K_FACTOR:      k_ff   <= csr_data;
               CSR_CAPACITY_FLOW: cap_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (req_acc) begin
            unique case (req_data.command)
               CMD_PULSE: begin
                  if (pulse_count_ff != '1) pulse_count_ff <= pulse_count_ff + 1'b1;
               end
               CMD_RESTART: pulse_count_ff <= '0;
               default: begin
               end
            endcase
         end
         if (acc_go) begin
            pulse_count_ff <= '0;
            vol_sum_ff     <= vol_sum_in;
            dur_sum_ff     <= dur_sum_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc && req_data.command == CMD_UPDATE) dur_ff <= req_data.duration_ms;
      if (mul_en) prod_ff <= prod_in;
      // prod holds c*k while the decile numerator is formed
      if (state_ff == ST_MUL_DN) ck_ff <= prod_ff[31:0];
      if (div_rsp.done) begin
         unique case (state_ff)
            ST_DIVW_F: freq_ff <= div_rsp.quot;
            ST_DIVW_D: dec_ff  <= dec_q;
            ST_DIVW_R: rate_ff <= div_rsp.quot[23:0];
            ST_DIVW_V: vol_ff  <= div_rsp.quot;
            default: begin
            end
         endcase
      end
      if (acc_go) begin
         rsp_data_ff.frequency       <= freq_ff;
         rsp_data_ff.decile          <= dec_ff;
         rsp_data_ff.flow_rate       <= rate_ff;
         rsp_data_ff.interval_volume <= vol_ff;
         rsp_data_ff.total_volume    <= vol_sum_in;
         rsp_data_ff.total_time      <= dur_sum_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACC))
      else $error("result raised outside the final update step");

   a_decile_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.decile <= DEC_MAX)
      else $error("decile beyond table depth");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      acc_go |=> pulse_count_ff == '0 && state_ff == ST_IDLE)
      else $error("pulse count not cleared after update");

endmodule

@@ dv/totalizer_checker.sv @@
// ----------------------------------------------------------------------------
// totalizer_checker
// Watches the req, rsp and csr channels of the flow pulse totalizer, keeps
// its own copy of the counter, the m-factor table, the totals and the
// registers, works out every interval reading and compares each rsp
// transfer field by field with the oldest reading still owed.
// ----------------------------------------------------------------------------
module totalizer_checker #(
   parameter int TABLE_DEPTH = fpt_pkg::TABLE_DEPTH_DEF,
   parameter int PULSE_BITS  = fpt_pkg::PULSE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  fpt_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  fpt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [fpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                        csr_data,
   input  logic                               run_done,
   output int                                 failures,
   output int                                 outstanding
);
   import fpt_pkg::*;

   localparam logic [63:0] MAX24 = 64'hFF_FFFF;
   localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
   localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
   localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

   logic [15:0]           k_factor;
   logic [15:0]           capacity;
   logic [PULSE_BITS-1:0] pulse_count;
   logic [15:0]           m_table [TABLE_DEPTH];
   logic [63:0]           volume_total;
   logic [63:0]           time_total;
   rsp_type               expected_readings [$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   // a zero divisor gives all ones, which then saturates like any value
   function automatic logic [63:0] floor_div(input logic [63:0] num, input logic [63:0] den);
      return (den == 64'd0) ? {64{1'b1}} : num / den;
   endfunction

   function automatic logic [63:0] clip(input logic [63:0] value, input logic [63:0] limit);
      return (value > limit) ? limit : value;
   endfunction

   function automatic rsp_type close_interval(input logic [15:0] duration);
      logic [63:0] pulses;
      logic [63:0] freq;
      logic [63:0] tier;
      logic [63:0] m_factor;
      logic [63:0] rate;
      logic [63:0] volume;
      rsp_type     reading;
      pulses   = 64'(pulse_count);
      freq     = clip(floor_div(pulses * 64'(FREQ_SCALE), 64'(duration)), MAX32);
      tier     = floor_div(64'(TABLE_DEPTH) * 64'd256 * freq, 64'(capacity) * 64'(k_factor));
      if (tier > 64'(TABLE_DEPTH - 1)) begin
         tier = 64'(TABLE_DEPTH - 1);
      end
      m_factor = 64'(m_table[tier]);
      rate     = clip(floor_div(freq * m_factor, 64'd64 * 64'(k_factor)), MAX24);
      volume   = clip(floor_div(pulses * m_factor * 64'(VOL_SCALE), 64'd12 * 64'(k_factor)),
                      MAX32);
      pulse_count  = '0;
      volume_total = clip(volume_total + volume, MAX48);
      time_total   = clip(time_total + 64'(duration), MAX40);
      reading.frequency       = freq[31:0];
      reading.decile          = tier[3:0];
      reading.flow_rate       = rate[23:0];
      reading.interval_volume = volume[31:0];
      reading.total_volume    = volume_total[47:0];
      reading.total_time      = time_total[39:0];
      return reading;
   endfunction

   task automatic apply_request(input req_type item);
      case (cmd_type'(item.command))
         CMD_PULSE: begin
            if (pulse_count != {PULSE_BITS{1'b1}}) begin
               pulse_count = pulse_count + 1'b1;
            end
         end
         CMD_LOAD: begin
            // out of range entries are dropped
            if (item.table_index < TABLE_DEPTH) begin
               m_table[item.table_index] = item.table_value;
            end
         end
         CMD_RESTART: begin
            pulse_count = '0;
         end
         default: begin
            expected_readings.push_back(close_interval(item.duration_ms));
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_reading(input rsp_type got);
      rsp_type want;
      if (expected_readings.size() == 0) begin
         $display("%0t: unexpected rsp transfer, expected none, actual %h", $time, got);
         failures++;
      end else begin
         want = expected_readings.pop_front();
         compare_field("frequency", want.frequency, got.frequency);
         compare_field("decile", want.decile, got.decile);
         compare_field("flow_rate", want.flow_rate, got.flow_rate);
         compare_field("interval_volume", want.interval_volume, got.interval_volume);
         compare_field("total_volume", want.total_volume, got.total_volume);
         compare_field("total_time", want.total_time, got.total_time);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         k_factor     = K_FACTOR_RESET;
         capacity     = CAPACITY_RESET;
         pulse_count  = '0;
         volume_total = '0;
         time_total   = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            m_table[i] = '0;
         end
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_reading(rsp_data);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_K_FACTOR:      k_factor = csr_data;
               CSR_CAPACITY_FLOW: capacity = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            apply_request(req_data);
         end
      end
      outstanding = expected_readings.size();
   end

   always @(posedge run_done) begin
      if (expected_readings.size() != 0) begin
         $display("%0t: readings never delivered, expected 0 left, actual %0d left",
                  $time, expected_readings.size());
         failures++;
      end
   end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the flow pulse totalizer with a directed opening (table loads,
// restarts, zero and full-scale intervals) and then random pulse intervals
// under several k-factor and capacity settings, with random idling on both
// channels and one long rsp hold-off. The checker does the prediction.
// ----------------------------------------------------------------------------
module testbench;
   import fpt_pkg::*;

   localparam int RESULT_LATENCY = 150;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int HOLD_CYCLES    = 600;
   localparam int PHASE_ITEMS    = 295;
   localparam int PHASE_COUNT    = 6;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   req_type                   req_data  = '0;
   logic                      rsp_stall = 1'b0;
   logic                      csr_valid = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_K_FACTOR;
   logic [15:0]               csr_data  = '0;
   logic                      run_done  = 1'b0;
   logic                      req_stall;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_ready;
   int                        failures;
   int                        outstanding;

   int items_sent = 0;
   bit no_idle    = 1'b0;
   bit long_hold  = 1'b0;

   // k-factor and capacity per phase; the random phase overrides its entry
   logic [15:0] k_steps   [PHASE_COUNT] = '{16'd1, 16'd65535, 16'd0, 16'd1, 16'd0, 16'd1920};
   logic [15:0] cap_steps [PHASE_COUNT] = '{16'd1, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd7680};

   always #4 clock = ~clock;

   flow_pulse_totalizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   totalizer_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .run_done    (run_done),
      .failures    (failures),
      .outstanding (outstanding)
   );

   task automatic send_item(input cmd_type cmd, input logic [15:0] duration,
                            input logic [3:0] index, input logic [15:0] value);
      int      gap;
      req_type item;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      item.command     = cmd;
      item.duration_ms = duration;
      item.table_index = index;
      item.table_value = value;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_pulses(input int count);
      repeat (count) send_item(CMD_PULSE, 16'($urandom), 4'($urandom), 16'($urandom));
   endtask

   task automatic send_update(input logic [15:0] duration);
      send_item(CMD_UPDATE, duration, 4'($urandom), 16'($urandom));
   endtask

   // wait for all readings or the drain limit, then let any pulse or load finish
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] k_value, input logic [15:0] cap_value);
      csr_index <= CSR_K_FACTOR;
      csr_data  <= k_value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_CAPACITY_FLOW;
      csr_data  <= cap_value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one measurement interval, sometimes broken up or replaced by noise
   task automatic run_interval();
      int          pick;
      int          count;
      logic [15:0] duration;
      no_idle = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 19);
      if (pick < 2) begin
         send_item(cmd_type'(2'($urandom_range(0, 3))), 16'($urandom), 4'($urandom),
                   16'($urandom));
      end else begin
         if (pick < 4) begin
            send_item(CMD_RESTART, 16'($urandom), 4'($urandom), 16'($urandom));
         end
         count = (pick == 19) ? $urandom_range(200, 400) : $urandom_range(0, 24);
         send_pulses(count);
         if (pick == 4 || pick == 5) begin
            // restart in the middle of an interval
            send_item(CMD_RESTART, 16'($urandom), 4'($urandom), 16'($urandom));
            send_pulses($urandom_range(0, 6));
         end
         if (pick >= 6 && pick < 9) begin
            send_item(CMD_LOAD, 16'($urandom), 4'($urandom_range(0, 15)), 16'($urandom));
         end
         case ($urandom_range(0, 15))
            0:       duration = 16'd0;
            1, 2:    duration = 16'($urandom);
            default: duration = 16'($urandom_range(1, 64));
         endcase
         send_update(duration);
      end
   endtask

   // receiver: random stall before each transfer, one long hold on request
   initial begin
      int pause;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            pause     = HOLD_CYCLES;
            long_hold = 1'b0;
         end else if (no_idle) begin
            pause = 0;
         end else begin
            pause = $urandom_range(0, 4);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #8_000_000;
      $display("flow_pulse_totalizer test failed");
      $finish;
   end

   initial begin
      int          phase_start;
      logic [15:0] k_value;
      logic [15:0] cap_value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table first so no update reads an empty entry
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         send_item(CMD_LOAD, 16'($urandom), 4'(i),
                   (i == 0) ? 16'h0000 : (i == TABLE_DEPTH_DEF - 1) ? 16'hFFFF : 16'($urandom));
      end
      send_item(CMD_LOAD, 16'($urandom), 4'd15, 16'h1234);
      send_item(CMD_LOAD, 16'($urandom), 4'(TABLE_DEPTH_DEF), 16'hFFFF);
      send_update(16'd1);
      send_pulses(3);
      send_item(CMD_RESTART, 16'hFFFF, 4'hF, 16'hFFFF);
      send_pulses(2);
      send_update(16'hFFFF);
      send_pulses(4);
      send_update(16'd0);
      send_update(16'd0);
      send_pulses(1);
      send_update(16'd1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         k_value   = (phase == 4) ? 16'($urandom_range(1, 65535)) : k_steps[phase];
         cap_value = (phase == 4) ? 16'($urandom_range(1, 65535)) : cap_steps[phase];
         write_config(k_value, cap_value);
         phase_start = items_sent;
         if (phase == 4) begin
            // hold rsp off while updates keep coming so the block backs up
            long_hold = 1'b1;
            no_idle   = 1'b1;
            repeat (6) begin
               send_pulses(3);
               send_update(16'($urandom_range(1, 64)));
            end
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            run_interval();
         end
      end

      settle();
      run_done = 1'b1;
      @(posedge clock);
      if (failures == 0) begin
         $display("flow_pulse_totalizer test passed");
      end else begin
         $display("flow_pulse_totalizer test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fpt_pkg.sv
rtl/fpt_div.sv
rtl/fpt_mtab.sv
rtl/flow_pulse_totalizer.sv
dv/totalizer_checker.sv
dv/testbench.sv
